// ===== sv/zla_pkg.sv =====
// Shared types and codes for the zone lifetime allocator.
`timescale 1ns / 1ps
`default_nettype none
package zla_pkg;

   localparam int unsigned IDX_W = 10;   // zone index, up to 1024 zones
   localparam int unsigned CNT_W = 11;   // count of zones, up to 1024
   localparam int unsigned BLK_W = 21;   // block counts and offsets
   localparam int unsigned LIM_W = 7;    // zone limits and counters

   localparam logic [2:0] FN_ALLOC   = 3'd0;
   localparam logic [2:0] FN_APPEND  = 3'd1;
   localparam logic [2:0] FN_CLOSE   = 3'd2;
   localparam logic [2:0] FN_RELEASE = 3'd3;
   localparam logic [2:0] FN_RESET   = 3'd4;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_NO_SLOT  = 3'd1;
   localparam logic [2:0] ST_NO_ZONE  = 3'd2;
   localparam logic [2:0] ST_NO_SPACE = 3'd3;
   localparam logic [2:0] ST_WRONG    = 3'd4;

   localparam logic [1:0] CSR_ZONE_CAP   = 2'd0;
   localparam logic [1:0] CSR_MAX_ACTIVE = 2'd1;
   localparam logic [1:0] CSR_MAX_OPEN   = 2'd2;

   typedef struct packed {
      logic [2:0]       func;
      logic [2:0]       hint;
      logic [5:0]       sel;
      logic [BLK_W-1:0] amount;
   } cmd_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
      logic             set_life;
      logic [2:0]       life;
   } commit_type;

   typedef struct packed {
      logic [7:0]       best;
      logic             have;
      logic [IDX_W-1:0] cand;
      logic [BLK_W-1:0] cand_cap;
      logic             emp_have;
      logic [IDX_W-1:0] emp_idx;
      logic [2:0]       status;
      logic [BLK_W-1:0] capl;
      logic             closed;
      logic             close_full;
      logic [LIM_W-1:0] nreset;
      logic [CNT_W-1:0] ndec;
   } acc_type;

endpackage
`default_nettype wire

// ===== sv/zla_cell.sv =====
// One zone entry of the allocator chain with its stage of the scan.
`timescale 1ns / 1ps
`default_nettype none
module zla_cell #(
   parameter int unsigned IDX = 0,
   parameter int unsigned DIFF_NOT_GOOD = 100
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [20:0]         cap,
   input  zla_pkg::cmd_type    cmd,
   input  zla_pkg::commit_type commit,
   input  logic                tok_in,
   input  zla_pkg::acc_type    acc_in,
   output logic                tok_out,
   output zla_pkg::acc_type    acc_out
);
   import zla_pkg::*;

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);
   localparam logic [7:0] DIFF = 8'(DIFF_NOT_GOOD);

   logic [BLK_W-1:0] off_ff, off_in, vld_ff, vld_in;
   logic             open_ff, open_in;
   logic [2:0]       life_ff, life_in;
   logic             tok_ff;
   acc_type          acc_ff, acc_in_n;

   logic             cap_ok, hit;
   logic [BLK_W-1:0] capl_own;
   logic [7:0]       diff;
   logic [BLK_W:0]   vld_sum;

   assign cap_ok   = cap > off_ff;
   assign capl_own = cap_ok ? cap - off_ff : '0;
   assign hit      = IDX_W'(cmd.sel) == MY_IDX;
   assign vld_sum  = {1'b0, vld_ff} + {1'b0, cmd.amount};

   always_comb begin
      if (cmd.hint <= 3'd1) begin
         diff = (life_ff == cmd.hint) ? 8'd0 : DIFF;
      end else if (life_ff > cmd.hint) begin
         diff = 8'(life_ff - cmd.hint);
      end else begin
         diff = DIFF;
      end
   end

   always_comb begin
      off_in   = off_ff;
      vld_in   = vld_ff;
      open_in  = open_ff;
      life_in  = life_ff;
      acc_in_n = acc_in;
      if (tok_in) begin
         case (cmd.func)
            FN_ALLOC: begin
               if (!open_ff && vld_ff != '0 && cap_ok && diff <= acc_in.best) begin
                  acc_in_n.best     = diff;
                  acc_in_n.have     = 1'b1;
                  acc_in_n.cand     = MY_IDX;
                  acc_in_n.cand_cap = capl_own;
               end
               if (!open_ff && off_ff == '0 && !acc_in.emp_have) begin
                  acc_in_n.emp_have = 1'b1;
                  acc_in_n.emp_idx  = MY_IDX;
               end
            end
            FN_APPEND: begin
               if (hit) begin
                  if (cmd.amount > capl_own) begin
                     acc_in_n.status = ST_NO_SPACE;
                     acc_in_n.capl   = capl_own;
                  end else begin
                     off_in        = off_ff + cmd.amount;
                     vld_in        = vld_sum[BLK_W] ? '1 : vld_sum[BLK_W-1:0];
                     acc_in_n.capl = capl_own - cmd.amount;
                  end
               end
            end
            FN_CLOSE: begin
               if (hit) begin
                  acc_in_n.capl = capl_own;
                  if (!open_ff) begin
                     acc_in_n.status = ST_WRONG;
                  end else begin
                     open_in             = 1'b0;
                     acc_in_n.closed     = 1'b1;
                     acc_in_n.close_full = !cap_ok;
                  end
               end
            end
            FN_RELEASE: begin
               if (hit) begin
                  acc_in_n.capl = capl_own;
                  if (cmd.amount > vld_ff) begin
                     acc_in_n.status = ST_WRONG;
                  end else begin
                     vld_in = vld_ff - cmd.amount;
                  end
               end
            end
            FN_RESET: begin
               if (vld_ff == '0 && !open_ff && off_ff != '0) begin
                  off_in  = '0;
                  life_in = 3'd0;
                  if (cap_ok) begin
                     acc_in_n.ndec = acc_in.ndec + 1'b1;
                  end
                  if (acc_in.nreset != '1) begin
                     acc_in_n.nreset = acc_in.nreset + 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
      if (commit.en && commit.idx == MY_IDX) begin
         open_in = 1'b1;
         if (commit.set_life) begin
            life_in = commit.life;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff  <= '0;
         vld_ff  <= '0;
         open_ff <= 1'b0;
         life_ff <= 3'd0;
         tok_ff  <= 1'b0;
      end else begin
         off_ff  <= off_in;
         vld_ff  <= vld_in;
         open_ff <= open_in;
         life_ff <= life_in;
         tok_ff  <= tok_in;
      end
      acc_ff <= acc_in_n;
   end

   assign tok_out = tok_ff;
   assign acc_out = acc_ff;
endmodule
`default_nettype wire

// ===== sv/zone_lifetime_allocator_unit.sv =====
// Top level of the zone lifetime allocator: control, counters and the cell chain.
`timescale 1ns / 1ps
`default_nettype none
// Each request (start high while busy is low) keeps busy high while a token
// carries the request through the chain of zone cells, one cell a cycle, and
// the commit state then opens the chosen zone. The
// response appears on the rsp_ ports for exactly one cycle, flagged by
// rsp_valid, in the last cycle of busy; it cannot be held off, so capture it
// then. Configuration writes (csr_we) take effect at once and belong in idle
// time only. Zone state and the open and active counts come out of reset
// cleared, the limits at their defaults.
module zone_lifetime_allocator_unit #(
   parameter int unsigned NUM_ZONES = 64,
   parameter int unsigned DIFF_NOT_GOOD = 100
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_func,
   input  logic [2:0]  req_lifetime,
   input  logic [5:0]  req_zone_sel,
   input  logic [20:0] req_amount,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [5:0]  rsp_zone_index,
   output logic        rsp_reused_zone,
   output logic [20:0] rsp_capacity_left,
   output logic [6:0]  rsp_zones_reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [20:0] csr_wdata
);
   import zla_pkg::*;

   localparam logic [7:0] DIFF = 8'(DIFF_NOT_GOOD);

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SCAN   = 3'b010,
      S_COMMIT = 3'b100
   } state_type;

   state_type        state_ff, state_in;
   cmd_type          req_ff;
   logic             tok0_ff;
   commit_type       commit_ff, commit_in;
   logic [BLK_W-1:0] cap_ff;
   logic [LIM_W-1:0] max_act_ff, max_open_ff;
   logic [LIM_W-1:0] open_ff, open_in, act_ff, act_in;

   logic             rsp_valid_ff;
   logic [2:0]       status_ff, status_in;
   logic [5:0]       zidx_ff, zidx_in;
   logic             reused_ff, reused_in;
   logic [BLK_W-1:0] capl_ff, capl_in;
   logic [LIM_W-1:0] nres_ff, nres_in;

   logic             tok [0:NUM_ZONES];
   acc_type          acc [0:NUM_ZONES];
   acc_type          acc0, fin;
   logic             accept, finish, out_of_range;

   assign accept = start && state_ff == S_IDLE;
   assign finish = state_ff == S_SCAN && tok[NUM_ZONES];
   assign busy   = state_ff != S_IDLE;

   // Scan seed: nothing found yet, best difference at the "not good" mark.
   always_comb begin
      acc0      = '0;
      acc0.best = DIFF;
   end
   assign tok[0] = tok0_ff;
   assign acc[0] = acc0;

   // The chain: every cell owns one zone and hands the running scan result on.
   for (genvar g = 0; g < NUM_ZONES; g++) begin : g_cell
      zla_cell #(
         .IDX(g),
         .DIFF_NOT_GOOD(DIFF_NOT_GOOD)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .cap    (cap_ff),
         .cmd    (req_ff),
         .commit (commit_ff),
         .tok_in (tok[g]),
         .acc_in (acc[g]),
         .tok_out(tok[g+1]),
         .acc_out(acc[g+1])
      );
   end

   assign fin          = acc[NUM_ZONES];
   assign out_of_range = 32'(req_ff.sel) >= 32'(NUM_ZONES);

   // Decide the response and the counter updates once the token leaves the chain.
   always_comb begin
      status_in = ST_OK;
      zidx_in   = 6'd0;
      reused_in = 1'b0;
      capl_in   = '0;
      nres_in   = '0;
      open_in   = open_ff;
      act_in    = act_ff;
      commit_in = '0;
      case (req_ff.func)
         FN_ALLOC: begin
            if (open_ff >= max_open_ff) begin
               status_in = ST_NO_SLOT;
            end else if (fin.best < DIFF) begin
               commit_in.en  = 1'b1;
               commit_in.idx = fin.cand;
               reused_in     = 1'b1;
               capl_in       = fin.cand_cap;
            end else if (act_ff < max_act_ff && fin.emp_have) begin
               // Fresh zone: tag it with the hint and count it as active.
               commit_in.en       = 1'b1;
               commit_in.idx      = fin.emp_idx;
               commit_in.set_life = 1'b1;
               commit_in.life     = req_ff.hint;
               capl_in            = cap_ff;
               act_in             = act_ff + 1'b1;
            end else if (fin.have) begin
               commit_in.en  = 1'b1;
               commit_in.idx = fin.cand;
               reused_in     = 1'b1;
               capl_in       = fin.cand_cap;
            end else begin
               status_in = ST_NO_ZONE;
            end
            if (commit_in.en) begin
               open_in = open_ff + 1'b1;
               zidx_in = 6'(commit_in.idx);
            end
         end
         FN_APPEND, FN_CLOSE, FN_RELEASE: begin
            zidx_in = req_ff.sel;
            if (out_of_range) begin
               status_in = ST_NO_ZONE;
            end else begin
               status_in = fin.status;
               capl_in   = fin.capl;
               if (fin.closed) begin
                  if (open_ff != '0) begin
                     open_in = open_ff - 1'b1;
                  end
                  if (fin.close_full && act_ff != '0) begin
                     act_in = act_ff - 1'b1;
                  end
               end
            end
         end
         FN_RESET: begin
            nres_in = fin.nreset;
            // Saturating decrement once for each partly written zone dropped.
            if (fin.ndec >= CNT_W'(act_ff)) begin
               act_in = '0;
            end else begin
               act_in = act_ff - LIM_W'(fin.ndec);
            end
         end
         default: begin
            status_in = ST_WRONG;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (tok[NUM_ZONES]) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tok0_ff      <= 1'b0;
         commit_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         open_ff      <= '0;
         act_ff       <= '0;
         cap_ff       <= 21'd262144;
         max_act_ff   <= 7'd13;
         max_open_ff  <= 7'd13;
      end else begin
         state_ff     <= state_in;
         tok0_ff      <= accept;
         commit_ff    <= finish ? commit_in : '0;
         rsp_valid_ff <= finish;
         if (finish) begin
            open_ff <= open_in;
            act_ff  <= act_in;
         end
         if (csr_we) begin
            case (csr_index)
               CSR_ZONE_CAP:   cap_ff      <= csr_wdata;
               CSR_MAX_ACTIVE: max_act_ff  <= csr_wdata[LIM_W-1:0];
               CSR_MAX_OPEN:   max_open_ff <= csr_wdata[LIM_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // Hold the request and the response payload; no reset needed.
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff.func   <= req_func;
         req_ff.hint   <= req_lifetime;
         req_ff.sel    <= req_zone_sel;
         req_ff.amount <= req_amount;
      end
      if (finish) begin
         status_ff <= status_in;
         zidx_ff   <= zidx_in;
         reused_ff <= reused_in;
         capl_ff   <= capl_in;
         nres_ff   <= nres_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_zone_index    = zidx_ff;
   assign rsp_reused_zone   = reused_ff;
   assign rsp_capacity_left = capl_ff;
   assign rsp_zones_reset   = nres_ff;
endmodule
`default_nettype wire

// ===== sv/zla_checker.sv =====
// Port-level checks for the zone lifetime allocator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module zla_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic [2:0] rsp_status,
   input logic [6:0] rsp_zones_reset
);
   import zla_pkg::*;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("request accepted but busy did not rise");

   a_rsp_in_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("response outside a busy request");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid && !busy)
      else $error("response longer than one cycle or busy held");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ST_WRONG)
      else $error("undefined status code");

   a_reset_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zones_reset != 7'd0 |-> rsp_status == ST_OK)
      else $error("zones reset with a failing status");
endmodule

bind zone_lifetime_allocator_unit zla_checker u_zla_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_status     (rsp_status),
   .rsp_zones_reset(rsp_zones_reset)
);
`default_nettype wire
